/* sv/i64alu_pkg.sv */
// ----------------------------------------------------------------------------
// i64alu_pkg
// Opcodes, error codes and field widths shared by the 64-bit integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package i64alu_pkg;
	localparam int unsigned DataW = 64;
	localparam int unsigned OpW   = 4;
	localparam int unsigned ErrW  = 2;

	localparam logic [OpW-1:0] OP_ADD = 4'd0;
	localparam logic [OpW-1:0] OP_SUB = 4'd1;
	localparam logic [OpW-1:0] OP_MUL = 4'd2;
	localparam logic [OpW-1:0] OP_DIV = 4'd3;
	localparam logic [OpW-1:0] OP_MOD = 4'd4;
	localparam logic [OpW-1:0] OP_POW = 4'd5;
	localparam logic [OpW-1:0] OP_NEG = 4'd6;
	localparam logic [OpW-1:0] OP_EQ  = 4'd7;
	localparam logic [OpW-1:0] OP_LT  = 4'd8;
	localparam logic [OpW-1:0] OP_LE  = 4'd9;

	localparam logic [ErrW-1:0] ERR_OK   = 2'd0;
	localparam logic [ErrW-1:0] ERR_DIV0 = 2'd1;
	localparam logic [ErrW-1:0] ERR_MOD0 = 2'd2;
	localparam logic [ErrW-1:0] ERR_NEXP = 2'd3;
endpackage
`default_nettype wire

/* sv/int64_integer_alu.sv */
// ----------------------------------------------------------------------------
// int64_integer_alu
// Signed 64-bit ALU: add, sub, mul, div, mod, pow, negate and compares,
// built around one bit-serial shift-and-add / restoring-divide unit.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   req_type[3:0], operand_a[67:4], operand_b  -
//                [131:68], zero pad to 136 bits
// m_axis   out  result_value[63:0], error_code[65:64],      -
//                zero pad to 72 bits
//
// Add, subtract, negate and compares are computed at accept and go out via ST_OUT.
// Multiply and divide/remainder take one shift step per bit: 64 steps, then
// a sign fix-up in ST_DFIX for divide/remainder. Power runs one 64-step
// multiply per squaring and per set exponent bit, up to 126 multiplies.
// One item is in work at a time; the result register holds until taken.
// Reset clears the control state only.
// ----------------------------------------------------------------------------
`default_nettype none
module int64_integer_alu (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [135:0] s_axis_tdata,  // req_type, operand_a, operand_b
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [71:0]       m_axis_tdata   // result_value, error_code
);
	localparam int unsigned W = i64alu_pkg::DataW;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_MUL   = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_DFIX  = 4'd3;
	localparam logic [3:0] ST_PSTEP = 4'd4;
	localparam logic [3:0] ST_PMUL  = 4'd5;
	localparam logic [3:0] ST_OUT   = 4'd6;
	localparam logic [3:0] ST_PACC  = 4'd7;
	localparam logic [3:0] ST_PSQ   = 4'd8;

	logic [3:0]     state_q;
	logic [3:0]     op_q;
	logic [W-1:0]   a_q, b_q;
	logic [W-1:0]   mcand_q, mplier_q, prod_q;
	logic [W-1:0]   rem_q, quo_q, dvsr_q;
	logic [W-1:0]   base_q, expo_q, acc_q;
	logic           pow_sq_q;
	logic [6:0]     cnt_q;
	logic [W-1:0]   res_q;
	logic [1:0]     err_q;
	logic           ovalid_q;

	logic [3:0]     in_op;
	logic [W-1:0]   in_a, in_b;
	logic [W:0]     trial;
	logic [W-1:0]   rem_sh;
	logic [W-1:0]   mag_a, mag_b;
	logic           slt;
	logic [W-1:0]   quick_res;
	logic [1:0]     quick_err;
	logic [3:0]     start_state;

	assign in_op = s_axis_tdata[3:0];
	assign in_a  = s_axis_tdata[67:4];
	assign in_b  = s_axis_tdata[131:68];
	assign mag_a = in_a[W-1] ? (~in_a + 1'b1) : in_a;
	assign mag_b = in_b[W-1] ? (~in_b + 1'b1) : in_b;
	assign slt   = $signed(in_a) < $signed(in_b);

	// Restoring divide step: shift in next dividend bit, try subtract.
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};
	assign trial  = {1'b0, rem_sh} - {1'b0, dvsr_q};

	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'd0, err_q, res_q};

	// Combinational quick results, error checks and the first state of each request.
	always_comb begin
		quick_res   = '0;
		quick_err   = i64alu_pkg::ERR_OK;
		start_state = ST_OUT;
		case (in_op)
			i64alu_pkg::OP_ADD: quick_res = in_a + in_b;
			i64alu_pkg::OP_SUB: quick_res = in_a - in_b;
			i64alu_pkg::OP_NEG: quick_res = ~in_a + 1'b1;
			i64alu_pkg::OP_EQ:  quick_res = W'(in_a == in_b);
			i64alu_pkg::OP_LT:  quick_res = W'(slt);
			i64alu_pkg::OP_LE:  quick_res = W'(slt || in_a == in_b);
			i64alu_pkg::OP_MUL: start_state = ST_MUL;
			i64alu_pkg::OP_DIV, i64alu_pkg::OP_MOD: begin
				if (in_b == '0) begin
					quick_err = (in_op == i64alu_pkg::OP_DIV) ?
						i64alu_pkg::ERR_DIV0 : i64alu_pkg::ERR_MOD0;
				end else begin
					start_state = ST_DIV;
				end
			end
			i64alu_pkg::OP_POW: begin
				if (in_b[W-1]) begin
					quick_err = i64alu_pkg::ERR_NEXP;
				end else begin
					start_state = ST_PSTEP;
				end
			end
			default: quick_res = '0;
		endcase
	end

	// Sequencer and bit-serial datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			pow_sq_q <= 1'b0;
		end else begin
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			case (state_q)
				// Capture the request and preload every serial unit.
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q     <= in_op;
						a_q      <= in_a;
						b_q      <= in_b;
						err_q    <= quick_err;
						res_q    <= quick_res;
						state_q  <= start_state;
						mcand_q  <= in_a;
						mplier_q <= in_b;
						prod_q   <= '0;
						cnt_q    <= '0;
						quo_q    <= mag_a;
						dvsr_q   <= mag_b;
						rem_q    <= '0;
						base_q   <= in_a;
						expo_q   <= in_b;
						acc_q    <= W'(1);
					end
				end
				// One multiplier bit per cycle, LSB first; product wraps.
				ST_MUL, ST_PMUL: begin
					if (mplier_q[0]) prod_q <= prod_q + mcand_q;
					mcand_q  <= {mcand_q[W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[W-1:1]};
					cnt_q    <= cnt_q + 7'd1;
					if (cnt_q == 7'(W - 1)) begin
						if (state_q == ST_MUL) state_q <= ST_OUT;
						else state_q <= pow_sq_q ? ST_PSQ : ST_PACC;
					end
				end
				ST_DIV: begin
					if (!trial[W]) rem_q <= trial[W-1:0];
					else rem_q <= rem_sh;
					quo_q <= {quo_q[W-2:0], !trial[W]};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'(W - 1)) state_q <= ST_DFIX;
				end
				// Apply signs: quotient by sign mismatch, remainder by dividend.
				ST_DFIX: begin
					if (op_q == i64alu_pkg::OP_DIV)
						res_q <= (a_q[W-1] ^ b_q[W-1]) ? (~quo_q + 1'b1) : quo_q;
					else
						res_q <= a_q[W-1] ? (~rem_q + 1'b1) : rem_q;
					state_q <= ST_OUT;
				end
				// Power: multiply acc by base if exponent bit set, then square.
				ST_PSTEP: begin
					if (expo_q == '0) begin
						res_q   <= acc_q;
						state_q <= ST_OUT;
					end else if (expo_q[0]) begin
						mcand_q  <= acc_q;
						mplier_q <= base_q;
						prod_q   <= '0;
						cnt_q    <= '0;
						pow_sq_q <= 1'b0;
						state_q  <= ST_PMUL;
					end else begin
						mcand_q  <= base_q;
						mplier_q <= base_q;
						prod_q   <= '0;
						cnt_q    <= '0;
						pow_sq_q <= 1'b1;
						state_q  <= ST_PMUL;
					end
				end
				ST_PACC: begin
					acc_q    <= prod_q;
					mcand_q  <= base_q;
					mplier_q <= base_q;
					prod_q   <= '0;
					cnt_q    <= '0;
					pow_sq_q <= 1'b1;
					state_q  <= ST_PMUL;
				end
				ST_PSQ: begin
					base_q  <= prod_q;
					expo_q  <= {1'b0, expo_q[W-1:1]};
					state_q <= ST_PSTEP;
				end
				ST_OUT: begin
					if (op_q == i64alu_pkg::OP_MUL) res_q <= prod_q;
					ovalid_q <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
